@@ hw/rtl/mjt_pkg.sv @@
// Shared types, constants, saturation helpers and the micro-op program
// of the minimum-jerk trajectory sampler. No dependencies.
`default_nettype none

package mjt_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned RateW  = 10;
  localparam int unsigned DurW   = 16;
  localparam int unsigned CoefW  = 48;
  localparam int unsigned WideW  = 64;
  localparam int unsigned MagW   = 62;
  localparam int unsigned NumW   = 33;
  localparam int unsigned DenW   = 21;
  localparam int unsigned ProdW  = MagW + NumW;
  localparam int unsigned CntW   = $clog2(ProdW);
  localparam int unsigned FracSh = 32;
  localparam int unsigned PcW    = 5;
  localparam int unsigned InW    = 6 * DataW + DurW;
  localparam int unsigned OutW   = 4 * DataW;

  localparam logic [RateW-1:0] RateReset = 10'd20;
  localparam logic [PcW-1:0]   TickFirst = 5'd0;
  localparam logic [PcW-1:0]   LoadFirst = 5'd24;
  localparam logic [WideW-1:0] StepLim   = 64'h1000_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_COEF,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_MUL,
    MS_DIV,
    MS_DONE
  } mdu_state_e;

  typedef enum logic [3:0] {
    TERM_NONE,
    TERM_A1,
    TERM_A5,
    TERM_A20,
    TERM_A60,
    TERM_B1,
    TERM_B4,
    TERM_B12,
    TERM_B24,
    TERM_G1,
    TERM_G3,
    TERM_G6,
    TERM_V0,
    TERM_A0,
    TERM_DA,
    TERM_K
  } term_e;

  typedef enum logic [2:0] {
    NUM_F,
    NUM_K,
    NUM_KK,
    NUM_R,
    NUM_D,
    NUM_DD,
    NUM_P32
  } num_e;

  typedef enum logic [2:0] {
    DEN_FRAC,
    DEN_R,
    DEN_D,
    DEN_RR,
    DEN_2RR
  } den_e;

  typedef enum logic [3:0] {
    POST_F,
    POST_H,
    POST_SUM_P0,
    POST_SUM_V0,
    POST_SUM_A0,
    POST_SUM_ADD,
    POST_SUM_SET,
    POST_X,
    POST_YPRE,
    POST_Y,
    POST_ZPRE,
    POST_Z
  } post_e;

  typedef enum logic [2:0] {
    CM_NONE,
    CM_POS,
    CM_VEL,
    CM_ACC,
    CM_JRK
  } commit_e;

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_TICK,
    FIN_LOAD
  } fin_e;

  typedef struct packed {
    logic    use_h;
    term_e   term;
    num_e    num;
    den_e    den;
    post_e   post;
    commit_e commit;
    fin_e    fin;
  } op_t;

  typedef struct packed {
    logic [PcW-1:0] pc;
    logic           ready;
    logic           mdu_start;
    logic           post_en;
    logic           coef_en;
    logic           out_en;
  } ctrl_t;

  function automatic op_t mk_op(input logic use_h, input term_e term, input num_e num,
                                input den_e den, input post_e post, input commit_e commit,
                                input fin_e fin);
    op_t op;
    op.use_h  = use_h;
    op.term   = term;
    op.num    = num;
    op.den    = den;
    op.post   = post;
    op.commit = commit;
    op.fin    = fin;
    return op;
  endfunction

  // Each step runs one scaling or fractional product on the shared unit.
  function automatic op_t op_rom(input logic [PcW-1:0] pc);
    op_t op;
    case (pc)
      5'd0:  op = mk_op(1'b0, TERM_K,   NUM_P32, DEN_D,    POST_F,       CM_NONE, FIN_NONE);
      5'd1:  op = mk_op(1'b0, TERM_A1,  NUM_F,   DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd2:  op = mk_op(1'b1, TERM_B1,  NUM_F,   DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd3:  op = mk_op(1'b1, TERM_G1,  NUM_F,   DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd4:  op = mk_op(1'b1, TERM_NONE, NUM_F,  DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd5:  op = mk_op(1'b1, TERM_NONE, NUM_F,  DEN_FRAC, POST_SUM_P0,  CM_NONE, FIN_NONE);
      5'd6:  op = mk_op(1'b0, TERM_V0,  NUM_K,   DEN_R,    POST_SUM_ADD, CM_NONE, FIN_NONE);
      5'd7:  op = mk_op(1'b0, TERM_A0,  NUM_KK,  DEN_2RR,  POST_SUM_ADD, CM_POS,  FIN_NONE);
      5'd8:  op = mk_op(1'b0, TERM_A5,  NUM_F,   DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd9:  op = mk_op(1'b1, TERM_B4,  NUM_F,   DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd10: op = mk_op(1'b1, TERM_G3,  NUM_F,   DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd11: op = mk_op(1'b1, TERM_NONE, NUM_F,  DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd12: op = mk_op(1'b1, TERM_NONE, NUM_R,  DEN_D,    POST_SUM_V0,  CM_NONE, FIN_NONE);
      5'd13: op = mk_op(1'b0, TERM_A0,  NUM_K,   DEN_R,    POST_SUM_ADD, CM_VEL,  FIN_NONE);
      5'd14: op = mk_op(1'b0, TERM_A20, NUM_F,   DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd15: op = mk_op(1'b1, TERM_B12, NUM_F,   DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd16: op = mk_op(1'b1, TERM_G6,  NUM_F,   DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd17: op = mk_op(1'b1, TERM_NONE, NUM_R,  DEN_D,    POST_H,       CM_NONE, FIN_NONE);
      5'd18: op = mk_op(1'b1, TERM_NONE, NUM_R,  DEN_D,    POST_SUM_A0,  CM_ACC,  FIN_NONE);
      5'd19: op = mk_op(1'b0, TERM_A60, NUM_F,   DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd20: op = mk_op(1'b1, TERM_B24, NUM_F,   DEN_FRAC, POST_H,       CM_NONE, FIN_NONE);
      5'd21: op = mk_op(1'b1, TERM_G6,  NUM_R,   DEN_D,    POST_H,       CM_NONE, FIN_NONE);
      5'd22: op = mk_op(1'b1, TERM_NONE, NUM_R,  DEN_D,    POST_H,       CM_NONE, FIN_NONE);
      5'd23: op = mk_op(1'b1, TERM_NONE, NUM_R,  DEN_D,    POST_SUM_SET, CM_JRK,  FIN_TICK);
      5'd24: op = mk_op(1'b0, TERM_DA,  NUM_DD,  DEN_RR,   POST_X,       CM_NONE, FIN_NONE);
      5'd25: op = mk_op(1'b0, TERM_A0,  NUM_D,   DEN_R,    POST_YPRE,    CM_NONE, FIN_NONE);
      5'd26: op = mk_op(1'b1, TERM_NONE, NUM_D,  DEN_R,    POST_Y,       CM_NONE, FIN_NONE);
      5'd27: op = mk_op(1'b0, TERM_V0,  NUM_D,   DEN_R,    POST_ZPRE,    CM_NONE, FIN_NONE);
      5'd28: op = mk_op(1'b0, TERM_A0,  NUM_DD,  DEN_2RR,  POST_Z,       CM_NONE, FIN_LOAD);
      default: op = mk_op(1'b0, TERM_NONE, NUM_R, DEN_R,   POST_H,       CM_NONE, FIN_LOAD);
    endcase
    return op;
  endfunction

  function automatic logic [DataW-1:0] sat32(input logic signed [WideW-1:0] x);
    logic [DataW-1:0] r;
    if (x > 64'sh0000_0000_7fff_ffff) begin
      r = 32'h7fff_ffff;
    end else if (x < 64'shffff_ffff_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [WideW-1:0] clamp56(input logic signed [WideW-1:0] x);
    logic signed [WideW-1:0] r;
    if (x > 64'sh0100_0000_0000_0000) begin
      r = 64'sh0100_0000_0000_0000;
    end else if (x < 64'shff00_0000_0000_0000) begin
      r = 64'shff00_0000_0000_0000;
    end else begin
      r = x;
    end
    return r;
  endfunction

  function automatic logic signed [CoefW-1:0] clamp48(input logic signed [WideW-1:0] x);
    logic signed [CoefW-1:0] r;
    if (x > 64'sh0000_7fff_ffff_ffff) begin
      r = 48'sh7fff_ffff_ffff;
    end else if (x < 64'shffff_8000_0000_0000) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = x[CoefW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mjt_mdu.sv @@
// Shared shift-add multiplier and restoring divider: sign(x)*min(|x|*num/den, 2^60),
// or sign(x)*(|x|*num >> 32) in fraction mode. Depends on mjt_pkg.
`default_nettype none

module mjt_mdu
  import mjt_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [WideW-1:0] x_i,
  input  wire logic [NumW-1:0]         num_i,
  input  wire logic [DenW-1:0]         den_i,
  input  wire logic                    frac_i,
  output logic                         done_o,
  output logic signed [WideW-1:0]      res_o
);

  mdu_state_e st_q, st_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ProdW-1:0] prod_q;
  logic [MagW-1:0]  mcand_q;
  logic [DenW-1:0]  den_q, rem_q;
  logic             neg_q, frac_q;

  logic [WideW-1:0] xabs;
  logic [MagW:0]    psum;
  logic [DenW:0]    rsh, rdiff;
  logic             ge;
  logic [MagW:0]    rmag;
  logic signed [WideW-1:0] rs;

  assign xabs  = x_i[WideW-1] ? -x_i : x_i;
  assign psum  = {1'b0, prod_q[ProdW-1:NumW]} + {1'b0, (prod_q[0] ? mcand_q : '0)};
  assign rsh   = {rem_q, prod_q[ProdW-1]};
  assign rdiff = rsh - {1'b0, den_q};
  assign ge    = (rsh >= {1'b0, den_q});

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    case (st_q)
      MS_IDLE: begin
        if (start_i) begin
          st_d  = MS_MUL;
          cnt_d = CntW'(NumW - 1);
        end
      end
      MS_MUL: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          st_d  = frac_q ? MS_DONE : MS_DIV;
          cnt_d = CntW'(ProdW - 1);
        end
      end
      MS_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          st_d = MS_DONE;
        end
      end
      MS_DONE: st_d = MS_IDLE;
      default: st_d = MS_IDLE;
    endcase
  end

  always_comb begin
    done_o = (st_q == MS_DONE);
    if (frac_q) begin
      rmag = prod_q[ProdW-1:FracSh];
    end else if (prod_q > ProdW'(StepLim)) begin
      rmag = StepLim[MagW:0];
    end else begin
      rmag = prod_q[MagW:0];
    end
    rs    = WideW'($signed({1'b0, rmag}));
    res_o = neg_q ? -rs : rs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= MS_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == MS_IDLE && start_i) begin
      mcand_q <= xabs[MagW-1:0];
      neg_q   <= x_i[WideW-1];
      frac_q  <= frac_i;
      den_q   <= den_i;
      prod_q  <= {{MagW{1'b0}}, num_i};
      rem_q   <= '0;
    end else if (st_q == MS_MUL) begin
      prod_q <= {psum, prod_q[NumW-1:1]};
    end else if (st_q == MS_DIV) begin
      rem_q  <= ge ? rdiff[DenW-1:0] : rsh[DenW-1:0];
      prod_q <= {prod_q[ProdW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mjt_ctrl.sv @@
// Sequencer of the sampler: walks the micro-op program for a load or a tick and
// hands each step to the shared unit. Depends on mjt_pkg.
`default_nettype none

module mjt_ctrl
  import mjt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire logic tick_i,
  input  wire logic mdu_done_i,
  input  wire logic out_free_i,
  output ctrl_t     ctrl_o
);

  state_e         state_q, state_d;
  logic [PcW-1:0] pc_q, pc_d;
  op_t            op;

  assign op = op_rom(pc_q);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    case (state_q)
      ST_IDLE: begin
        if (load_i) begin
          state_d = ST_ISSUE;
          pc_d    = LoadFirst;
        end else if (tick_i) begin
          state_d = ST_ISSUE;
          pc_d    = TickFirst;
        end
      end
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mdu_done_i) begin
          case (op.fin)
            FIN_TICK: state_d = ST_OUT;
            FIN_LOAD: state_d = ST_COEF;
            default: begin
              state_d = ST_ISSUE;
              pc_d    = pc_q + 1'b1;
            end
          endcase
        end
      end
      ST_COEF: state_d = ST_IDLE;
      ST_OUT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.pc        = pc_q;
    ctrl_o.ready     = (state_q == ST_IDLE);
    ctrl_o.mdu_start = (state_q == ST_ISSUE);
    ctrl_o.post_en   = (state_q == ST_WAIT) && mdu_done_i;
    ctrl_o.coef_en   = (state_q == ST_COEF);
    ctrl_o.out_en    = (state_q == ST_OUT) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/min_jerk_trajectory_sampler_top.sv @@
// Top level of the single-axis minimum-jerk trajectory sampler: segment state,
// operand selection and result registers. Depends on mjt_pkg, mjt_ctrl, mjt_mdu.
//
// A slave stream takes one word per item. tuser selects the kind: 0 loads a
// segment (start and target state, duration in ticks), 1 asks for one sample.
// A load gives no word out; it solves the coefficients. A sample of an active
// segment returns position, velocity, acceleration and jerk on the master
// stream, with tlast set on the segment's final sample. A sample with no
// active segment is taken and gives nothing. All of this runs on the one
// shared shift-add multiplier and restoring divider, one fractional product or
// exact scaling per step, 24 steps per sample and 5 per load. tready is high
// only while the sequencer is idle. A finished sample waits in the output
// register while the master side stalls; the next item is taken meanwhile, and
// a further sample holds in its last step until the register frees. Reset
// clears the segment, sets the tick rate to 20 and drops tvalid. The tick rate
// is written through cfg_we_i; the user must write it only while the block is
// idle, which the block itself does not enforce.
`default_nettype none

module min_jerk_trajectory_sampler_top
  import mjt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [RateW-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // start_position, start_velocity, start_acceleration, target_position,
  // target_velocity, target_acceleration, duration_ticks
  input  wire logic [InW-1:0]   s_axis_tdata_i,
  // mode
  input  wire logic             s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // position, velocity, acceleration, jerk
  output logic [OutW-1:0]       m_axis_tdata_o,
  // last_sample
  output logic                  m_axis_tlast_o
);

  ctrl_t ctrl;
  op_t   op;

  logic [RateW-1:0] rate_q;
  logic signed [CoefW-1:0] a_q, b_q, g_q;
  logic signed [DataW-1:0] p0_q, v0_q, a0_q, pf_q, vf_q, af_q;
  logic [DurW-1:0] k_q, dur_q;
  logic            active_q;
  logic [NumW-1:0] f_q, f_d;
  logic signed [WideW-1:0] h_q, h_d, sum_q, sum_d;
  logic signed [WideW-1:0] xm_q, xm_d, ym_q, ym_d, zm_q, zm_d;
  logic [DataW-1:0] pos_q, vel_q, acc_q, jrk_q;
  logic [OutW-1:0]  m_data_q;
  logic             m_last_q, m_valid_q;

  logic             accept, load_go, tick_go, out_free, mdu_done;
  logic [DurW-1:0]  dur_in;
  logic [RateW-1:0] rate;
  logic [2*RateW-1:0] rr;
  logic [2*DurW-1:0]  kk, dd;
  logic signed [WideW-1:0] aw, bw, gw, term, x_op, mdu_res;
  logic [NumW-1:0] num_op;
  logic [DenW-1:0] den_op;
  logic signed [WideW-1:0] xodd, xh, alpha, beta, gamma;

  assign op       = op_rom(ctrl.pc);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign load_go  = accept && !s_axis_tuser_i;
  assign tick_go  = accept && s_axis_tuser_i && active_q;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign dur_in   = s_axis_tdata_i[InW-1:6*DataW];

  assign s_axis_tready_o = ctrl.ready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  mjt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load_go),
    .tick_i     (tick_go),
    .mdu_done_i (mdu_done),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  mjt_mdu u_mdu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.mdu_start),
    .x_i     (x_op),
    .num_i   (num_op),
    .den_i   (den_op),
    .frac_i  (op.den == DEN_FRAC),
    .done_o  (mdu_done),
    .res_o   (mdu_res)
  );

  always_comb begin
    rate = (rate_q == '0) ? RateW'(1) : rate_q;
    rr   = (2*RateW)'(rate) * (2*RateW)'(rate);
    kk   = (2*DurW)'(k_q) * (2*DurW)'(k_q);
    dd   = (2*DurW)'(dur_q) * (2*DurW)'(dur_q);
    aw   = WideW'(a_q);
    bw   = WideW'(b_q);
    gw   = WideW'(g_q);
  end

  always_comb begin
    case (op.term)
      TERM_A1:  term = aw;
      TERM_A5:  term = aw * 64'sd5;
      TERM_A20: term = aw * 64'sd20;
      TERM_A60: term = aw * 64'sd60;
      TERM_B1:  term = bw;
      TERM_B4:  term = bw * 64'sd4;
      TERM_B12: term = bw * 64'sd12;
      TERM_B24: term = bw * 64'sd24;
      TERM_G1:  term = gw;
      TERM_G3:  term = gw * 64'sd3;
      TERM_G6:  term = gw * 64'sd6;
      TERM_V0:  term = WideW'(v0_q);
      TERM_A0:  term = WideW'(a0_q);
      TERM_DA:  term = WideW'(af_q) - WideW'(a0_q);
      TERM_K:   term = $signed(WideW'(k_q));
      default:  term = '0;
    endcase
    x_op = (op.use_h ? h_q : '0) + term;

    case (op.num)
      NUM_F:   num_op = f_q;
      NUM_K:   num_op = NumW'(k_q);
      NUM_KK:  num_op = NumW'(kk);
      NUM_R:   num_op = NumW'(rate);
      NUM_D:   num_op = NumW'(dur_q);
      NUM_DD:  num_op = NumW'(dd);
      NUM_P32: num_op = {1'b1, {(NumW-1){1'b0}}};
      default: num_op = '0;
    endcase

    case (op.den)
      DEN_R:   den_op = DenW'(rate);
      DEN_D:   den_op = DenW'(dur_q);
      DEN_RR:  den_op = DenW'(rr);
      DEN_2RR: den_op = DenW'({rr, 1'b0});
      default: den_op = '0;
    endcase
  end

  always_comb begin
    f_d   = f_q;
    h_d   = h_q;
    sum_d = sum_q;
    xm_d  = xm_q;
    ym_d  = ym_q;
    zm_d  = zm_q;
    if (ctrl.post_en) begin
      case (op.post)
        POST_F:       f_d   = mdu_res[NumW-1:0];
        POST_H:       h_d   = mdu_res;
        POST_SUM_P0:  sum_d = WideW'(p0_q) + mdu_res;
        POST_SUM_V0:  sum_d = WideW'(v0_q) + mdu_res;
        POST_SUM_A0:  sum_d = WideW'(a0_q) + mdu_res;
        POST_SUM_ADD: sum_d = sum_q + mdu_res;
        POST_SUM_SET: sum_d = mdu_res;
        POST_X:       xm_d  = clamp56(mdu_res);
        POST_YPRE:    h_d   = WideW'(vf_q) - WideW'(v0_q) - mdu_res;
        POST_Y:       ym_d  = clamp56(mdu_res);
        POST_ZPRE:    sum_d = WideW'(pf_q) - WideW'(p0_q) - mdu_res;
        POST_Z:       zm_d  = clamp56(sum_q - mdu_res);
        default:      h_d   = h_q;
      endcase
    end
  end

  always_comb begin
    xodd  = xm_q + $signed({{(WideW-1){1'b0}}, xm_q[WideW-1]});
    xh    = xodd >>> 1;
    alpha = xh - ym_q * 64'sd3 + zm_q * 64'sd6;
    beta  = ym_q * 64'sd7 - xm_q - zm_q * 64'sd15;
    gamma = xh - ym_q * 64'sd4 + zm_q * 64'sd10;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= RateReset;
      a_q       <= '0;
      b_q       <= '0;
      g_q       <= '0;
      p0_q      <= '0;
      v0_q      <= '0;
      a0_q      <= '0;
      k_q       <= '0;
      dur_q     <= '0;
      active_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (load_go) begin
        p0_q     <= s_axis_tdata_i[DataW-1:0];
        v0_q     <= s_axis_tdata_i[2*DataW-1:DataW];
        a0_q     <= s_axis_tdata_i[3*DataW-1:2*DataW];
        dur_q    <= (dur_in == '0) ? DurW'(1) : dur_in;
        k_q      <= '0;
        active_q <= 1'b1;
      end
      if (ctrl.coef_en) begin
        a_q <= clamp48(alpha);
        b_q <= clamp48(beta);
        g_q <= clamp48(gamma);
      end
      if (ctrl.out_en) begin
        m_valid_q <= 1'b1;
        if (k_q >= dur_q) begin
          active_q <= 1'b0;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f_q   <= f_d;
    h_q   <= h_d;
    sum_q <= sum_d;
    xm_q  <= xm_d;
    ym_q  <= ym_d;
    zm_q  <= zm_d;
    if (load_go) begin
      pf_q <= s_axis_tdata_i[4*DataW-1:3*DataW];
      vf_q <= s_axis_tdata_i[5*DataW-1:4*DataW];
      af_q <= s_axis_tdata_i[6*DataW-1:5*DataW];
    end
    if (ctrl.post_en) begin
      case (op.commit)
        CM_POS:  pos_q <= sat32(sum_d);
        CM_VEL:  vel_q <= sat32(sum_d);
        CM_ACC:  acc_q <= sat32(sum_d);
        CM_JRK:  jrk_q <= sat32(sum_d);
        default: pos_q <= pos_q;
      endcase
    end
    if (ctrl.out_en) begin
      m_data_q <= {jrk_q, acc_q, vel_q, pos_q};
      m_last_q <= (k_q >= dur_q);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mjt_checker.sv @@
// Port-level checks of the sampler and the bind that attaches them to the top.
// Depends on mjt_pkg and min_jerk_trajectory_sampler_top.
`default_nettype none

module mjt_checker
  import mjt_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid_i,
  input wire logic             s_axis_tready_o,
  input wire logic             s_axis_tuser_i,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [OutW-1:0]  m_axis_tdata_o,
  input wire logic             m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i |=> !s_axis_tready_o)
    else $error("ready right after a load");

  a_no_fast_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("output word one cycle after an input word");

endmodule

bind min_jerk_trajectory_sampler_top mjt_checker u_mjt_checker (.*);

`default_nettype wire
